FILE: sv/gld_pkg.sv
package gld_pkg;

    localparam int HEIGHT_BITS    = 16;
    localparam int COUNT_BITS     = 6;
    localparam int POS_BITS       = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

    typedef enum logic
    {
        ACT_SAMPLE = 1'b0,
        ACT_FLUSH  = 1'b1
    } action_t;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    typedef struct packed
    {
        action_t action;
        height_t height;
    } item_t;

    typedef struct packed
    {
        logic [POS_BITS-1:0] peak_row;
        logic [POS_BITS-1:0] peak_column;
    } peak_t;

    // one column of the line store: the cell two rows up and the cell one row up
    typedef struct packed
    {
        height_t up;
        height_t center;
    } line_word_t;

endpackage

FILE: sv/grid_local_maximum_detector.sv
// Grid local maximum detector (4-neighbour, edges ignored).
// cfg channel: index 0 = row count, 1 = column count; each write restarts the
//   grid. Counts of 0 act as 1, counts above the maximum act as the maximum.
// item channel: one transaction per grid height in raster order, then one
//   flush transaction per column to decide the last row. Surplus samples,
//   early flushes and extra flushes are dropped.
// peak channel: (row, column) of each cell that is >= every existing
//   neighbour, in raster order. A cell is decided when the sample below it
//   (or its flush) is accepted; the result is registered in the output buffer.
// Throughput: one item per cycle while item_ready is high. The line store is a
//   two-read RAM addressed by the next-state counters, so the words for the
//   next cell are ready when its item arrives; compare and update are combinational.
// A two-entry output buffer decouples the sides: item_ready drops only while
//   both entries hold results the receiver has not taken.
// Reset: counts return to 1, counters to 0, output buffer empties. The line
//   store needs no clearing; every word read is written by the current grid.
module grid_local_maximum_detector #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gld_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gld_pkg::COUNT_BITS-1:0]      cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  gld_pkg::item_t                      item,
    output logic                                peak_valid,
    input  logic                                peak_ready,
    output gld_pkg::peak_t                      peak
);

    import gld_pkg::*;

    localparam int COL_BITS = $clog2(MAX_COLUMNS);

    logic [COUNT_BITS-1:0] row_count_reg, row_count_next;
    logic [COUNT_BITS-1:0] column_count_reg, column_count_next;
    logic [COUNT_BITS-1:0] input_row_reg, input_row_next;
    logic [COL_BITS-1:0]   input_column_reg, input_column_next;
    logic [COUNT_BITS-1:0] decide_row_reg, decide_row_next;
    logic [COL_BITS-1:0]   decide_column_reg, decide_column_next;
    height_t               left_reg, left_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    peak_t                 out_reg, out_next;
    peak_t                 skid_reg, skid_next;

    logic                  item_accept;
    logic                  sample_ok;
    logic                  flush_ok;
    logic                  decide_now;
    logic                  is_peak;
    logic                  push;
    logic                  pop;
    peak_t                 new_peak;
    height_t               center;
    height_t               up;
    height_t               right;
    height_t               below;

    logic                  wr_en;
    logic [COL_BITS-1:0]   wr_addr;
    line_word_t            wr_word;
    logic [COL_BITS-1:0]   rd_addr_a;
    logic [COL_BITS-1:0]   rd_addr_b;
    line_word_t            rd_word_a;
    line_word_t            rd_word_b;

    function automatic logic [COUNT_BITS-1:0] clamp_count(
        input logic [COUNT_BITS-1:0] v,
        input int                    maxv
    );
        logic [COUNT_BITS-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = COUNT_BITS'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = COUNT_BITS'(maxv);
        end
        return r;
    endfunction

    gld_ram #(
        .WIDTH ($bits(line_word_t)),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_word),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_word_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_word_b)
    );

    assign cfg_ready  = 1'b1;
    assign item_ready = !skid_valid_reg;
    assign peak_valid = out_valid_reg;
    assign peak       = out_reg;

    always_comb
    begin
        item_accept = item_valid && item_ready;
        sample_ok   = (item.action == ACT_SAMPLE) && (input_row_reg < row_count_reg);
        flush_ok    = (item.action == ACT_FLUSH) && (input_row_reg >= row_count_reg)
                      && (decide_row_reg < row_count_reg);
        decide_now  = item_accept && ((sample_ok && (input_row_reg != '0)) || flush_ok);

        // word A is the cell being decided, word B the one to its right
        center = $signed(rd_word_a.center);
        up     = $signed(rd_word_a.up);
        right  = $signed(rd_word_b.center);
        below  = $signed(item.height);

        is_peak = 1'b1;
        if (sample_ok && (below > center))
        begin
            is_peak = 1'b0;
        end
        if ((decide_row_reg != '0) && (up > center))
        begin
            is_peak = 1'b0;
        end
        if ((decide_column_reg != '0) && (left_reg > center))
        begin
            is_peak = 1'b0;
        end
        if ((int'(decide_column_reg) + 1 < int'(column_count_reg)) && (right > center))
        begin
            is_peak = 1'b0;
        end

        row_count_next     = row_count_reg;
        column_count_next  = column_count_reg;
        input_row_next     = input_row_reg;
        input_column_next  = input_column_reg;
        decide_row_next    = decide_row_reg;
        decide_column_next = decide_column_reg;
        left_next          = left_reg;

        if (item_accept && sample_ok)
        begin
            if (int'(input_column_reg) + 1 >= int'(column_count_reg))
            begin
                input_column_next = '0;
                input_row_next    = input_row_reg + 1'b1;
            end
            else
            begin
                input_column_next = input_column_reg + 1'b1;
            end
        end

        if (decide_now)
        begin
            left_next = center;
            if (int'(decide_column_reg) + 1 >= int'(column_count_reg))
            begin
                decide_column_next = '0;
                decide_row_next    = decide_row_reg + 1'b1;
            end
            else
            begin
                decide_column_next = decide_column_reg + 1'b1;
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_next    = clamp_count(cfg_data, MAX_ROWS);
                REG_COLUMN_COUNT: column_count_next = clamp_count(cfg_data, MAX_COLUMNS);
            endcase
            input_row_next     = '0;
            input_column_next  = '0;
            decide_row_next    = '0;
            decide_column_next = '0;
        end

        // rows shift down one place in the column word as each sample lands
        wr_en          = item_accept && sample_ok;
        wr_addr        = input_column_reg;
        wr_word.up     = rd_word_a.center;
        wr_word.center = item.height;

        // prefetch for the state after this edge
        rd_addr_a = (input_row_next < row_count_next) ? input_column_next
                                                      : decide_column_next;
        rd_addr_b = rd_addr_a + 1'b1;

        new_peak.peak_row    = POS_BITS'(decide_row_reg);
        new_peak.peak_column = POS_BITS'(decide_column_reg);
        push = decide_now && is_peak;
        pop  = out_valid_reg && peak_ready;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = new_peak;
                skid_valid_next = push;
            end
            else
            begin
                out_next        = new_peak;
                out_valid_next  = push;
            end
        end
        else if (push)
        begin
            skid_next       = new_peak;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= COUNT_BITS'(1);
            column_count_reg  <= COUNT_BITS'(1);
            input_row_reg     <= '0;
            input_column_reg  <= '0;
            decide_row_reg    <= '0;
            decide_column_reg <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            row_count_reg     <= row_count_next;
            column_count_reg  <= column_count_next;
            input_row_reg     <= input_row_next;
            input_column_reg  <= input_column_next;
            decide_row_reg    <= decide_row_next;
            decide_column_reg <= decide_column_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_stalled_peak_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !peak_ready) |=> skid_valid_reg)
        else $error("peak lost while output stalled");

    a_decide_lags_input: assert property (@(posedge clk) disable iff (!rst_n)
        decide_row_reg <= input_row_reg)
        else $error("decide position ahead of input position");

    a_column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(input_column_reg) < int'(column_count_reg))
        && (int'(decide_column_reg) < int'(column_count_reg)))
        else $error("column counter beyond column count");
`endif

endmodule

FILE: sv/gld_ram.sv
module gld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write-first: a read of the address being written returns the new data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_a))
        begin
            rd_data_a <= wr_data;
        end
        else
        begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b))
        begin
            rd_data_b <= wr_data;
        end
        else
        begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import gld_pkg::*;

    localparam int MAX_COLS  = 32;
    localparam int MAX_LINES = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COUNT_BITS-1:0]     cfg_data = '0;
    logic                      item_valid = 1'b0;
    logic                      item_ready;
    item_t                     item = '0;
    logic                      peak_valid;
    logic                      peak_ready = 1'b0;
    peak_t                     peak;

    grid_local_maximum_detector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .peak_valid (peak_valid),
        .peak_ready (peak_ready),
        .peak       (peak)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Peak predictor: line history, counts and scan positions
    // ---------------------------------------------------------------
    height_t     line_hist [0:2*MAX_COLS];
    int unsigned rows_in_use = 1;
    int unsigned cols_in_use = 1;
    int unsigned in_row, in_col, dec_row, dec_col;

    peak_t       expected_peaks [$];
    item_t       pending_items [$];

    int unsigned mismatches     = 0;
    int unsigned accepted_items = 0;
    int unsigned peaks_checked  = 0;
    int unsigned grids_run      = 0;
    bit          idle_on        = 1'b1;

    function automatic int unsigned clamp_count(logic [COUNT_BITS-1:0] v, int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return 32'(v);
    endfunction

    task automatic apply_count(logic [CFG_INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] v);
        if (idx == REG_ROW_COUNT)
            rows_in_use = clamp_count(v, MAX_LINES);
        else
            cols_in_use = clamp_count(v, MAX_COLS);
        in_row  = 0;
        in_col  = 0;
        dec_row = 0;
        dec_col = 0;
    endtask

    task automatic shift_height(height_t h);
        for (int i = 2 * MAX_COLS; i > 0; i--)
            line_hist[i] = line_hist[i-1];
        line_hist[0] = h;
    endtask

    // cell under decision sits cols_in_use entries back; newest entry is the one below
    task automatic decide_cell(bit has_below);
        int unsigned c;
        height_t     centre;
        bit          is_peak;
        peak_t       p;
        c       = cols_in_use;
        centre  = line_hist[c];
        is_peak = 1'b1;
        if (has_below && line_hist[0] > centre)
            is_peak = 1'b0;
        if (dec_row > 0 && line_hist[2*c] > centre)
            is_peak = 1'b0;
        if (dec_col > 0 && line_hist[c+1] > centre)
            is_peak = 1'b0;
        if (dec_col + 1 < c && line_hist[c-1] > centre)
            is_peak = 1'b0;
        if (is_peak)
        begin
            p.peak_row    = dec_row[POS_BITS-1:0];
            p.peak_column = dec_col[POS_BITS-1:0];
            expected_peaks.push_back(p);
        end
        dec_col++;
        if (dec_col >= c)
        begin
            dec_col = 0;
            dec_row++;
        end
    endtask

    task automatic predict_peak(item_t it);
        if (it.action == ACT_SAMPLE)
        begin
            if (in_row < rows_in_use)
            begin
                shift_height(it.height);
                if (in_row > 0)
                    decide_cell(1'b1);
                in_col++;
                if (in_col >= cols_in_use)
                begin
                    in_col = 0;
                    in_row++;
                end
            end
        end
        else if (in_row >= rows_in_use && dec_row < rows_in_use)
        begin
            shift_height('0);
            decide_cell(1'b0);
        end
    endtask

    initial
    begin
        for (int i = 0; i <= 2 * MAX_COLS; i++)
            line_hist[i] = '0;
    end

    // ---------------------------------------------------------------
    // Item driver
    // ---------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_peak(item);
                accepted_items++;
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 7);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Peak monitor
    // ---------------------------------------------------------------
    int unsigned stall_left = 0;
    peak_t       want_peak;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_ready <= 1'b0;
        end
        else
        begin
            if (peak_valid && peak_ready)
            begin
                if (expected_peaks.size() == 0)
                begin
                    $display("%0t: unexpected peak transaction, got row %0d column %0d",
                             $time, peak.peak_row, peak.peak_column);
                    mismatches++;
                end
                else
                begin
                    want_peak = expected_peaks.pop_front();
                    peaks_checked++;
                    if (peak.peak_row !== want_peak.peak_row)
                    begin
                        $display("%0t: peak_row mismatch, expected %0d, actual %0d",
                                 $time, want_peak.peak_row, peak.peak_row);
                        mismatches++;
                    end
                    if (peak.peak_column !== want_peak.peak_column)
                    begin
                        $display("%0t: peak_column mismatch, expected %0d, actual %0d",
                                 $time, want_peak.peak_column, peak.peak_column);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                peak_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                peak_ready <= 1'b0;
            end
            else
            begin
                peak_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_item(action_t act, height_t h);
        item_t it;
        it.action = act;
        it.height = h;
        pending_items.push_back(it);
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_peaks.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // called at a clock edge; returns at the edge where the write is taken
    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_count(idx, v);
    endtask

    task automatic set_counts(logic [COUNT_BITS-1:0] rows, logic [COUNT_BITS-1:0] cols);
        @(posedge clk);
        cfg_write(REG_ROW_COUNT, rows);
        cfg_write(REG_COLUMN_COUNT, cols);
        cfg_valid <= 1'b0;
        grids_run++;
    endtask

    function automatic height_t pick_height(bit plateau, logic [HEIGHT_BITS-1:0] base);
        if (plateau)
            return height_t'(base + HEIGHT_BITS'($urandom_range(0, 2)));
        case ($urandom_range(0, 9))
            0:       return height_t'({1'b1, {(HEIGHT_BITS-1){1'b0}}});
            1:       return height_t'({1'b0, {(HEIGHT_BITS-1){1'b1}}});
            default: return height_t'($urandom);
        endcase
    endfunction

    localparam height_t H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    localparam height_t H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};

    initial
    begin
        logic [COUNT_BITS-1:0]  rows_raw, cols_raw;
        logic [HEIGHT_BITS-1:0] base;
        int unsigned            n_rows, n_cols, total, cut, pause_at, grid_items;
        bit                     noisy, plateau;

        grid_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // 1x1 grid from reset: early flush, surplus sample, deciding flush, extra flush
        queue_item(ACT_FLUSH, H_MAX);
        queue_item(ACT_SAMPLE, H_MIN);
        queue_item(ACT_SAMPLE, H_MAX);
        queue_item(ACT_FLUSH, '0);
        queue_item(ACT_FLUSH, '0);
        wait_idle();

        // 2x3: ties count as peaks, bottom-right corner tie with its left neighbour
        set_counts(6'd2, 6'd3);
        queue_item(ACT_SAMPLE, 16'sd7);
        queue_item(ACT_SAMPLE, H_MAX);
        queue_item(ACT_SAMPLE, 16'sd7);
        queue_item(ACT_SAMPLE, H_MIN);
        wait_idle();
        queue_item(ACT_SAMPLE, H_MAX);
        queue_item(ACT_SAMPLE, H_MAX);
        repeat (3) queue_item(ACT_FLUSH, '0);
        wait_idle();

        // partial grid, then a register write restarts it
        set_counts(6'd2, 6'd2);
        queue_item(ACT_SAMPLE, 16'sd1);
        queue_item(ACT_SAMPLE, 16'sd0);
        queue_item(ACT_SAMPLE, 16'sd0);
        wait_idle();

        // zero counts act as one
        set_counts(6'd0, 6'd0);
        queue_item(ACT_SAMPLE, 16'sd0);
        queue_item(ACT_FLUSH, 16'sd0);
        wait_idle();

        while (grid_items < 400)
        begin
            case ($urandom_range(0, 15))
                0:
                begin
                    rows_raw = $urandom_range(0, 1) ? 6'd32 : 6'd63;
                    cols_raw = COUNT_BITS'($urandom_range(1, 2));
                end
                1:
                begin
                    rows_raw = COUNT_BITS'($urandom_range(1, 2));
                    cols_raw = $urandom_range(0, 1) ? 6'd32 : 6'd63;
                end
                default:
                begin
                    rows_raw = COUNT_BITS'($urandom_range(0, 6));
                    cols_raw = COUNT_BITS'($urandom_range(0, 6));
                end
            endcase
            idle_on = (grid_items < 300);
            set_counts(rows_raw, cols_raw);
            n_rows   = clamp_count(rows_raw, MAX_LINES);
            n_cols   = clamp_count(cols_raw, MAX_COLS);
            total    = n_rows * n_cols;
            noisy    = ($urandom_range(0, 3) == 0);
            plateau  = ($urandom_range(0, 1) == 1);
            base     = HEIGHT_BITS'($urandom);
            cut      = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : total;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total + 1;

            for (int k = 0; k < cut; k++)
            begin
                if (k == pause_at)
                    wait_idle();
                if (noisy && $urandom_range(0, 15) == 0)
                    queue_item(ACT_FLUSH, height_t'($urandom));
                queue_item(ACT_SAMPLE, pick_height(plateau, base));
                grid_items++;
            end
            if (cut == total)
            begin
                if (noisy)
                    repeat ($urandom_range(1, 3)) queue_item(ACT_SAMPLE, height_t'($urandom));
                for (int k = 0; k < n_cols; k++)
                begin
                    queue_item(ACT_FLUSH, height_t'($urandom));
                    grid_items++;
                end
                if (noisy)
                    repeat ($urandom_range(1, 3)) queue_item(ACT_FLUSH, height_t'($urandom));
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expected_peaks.size() != 0)
        begin
            $display("%0t: %0d expected peaks never arrived", $time, expected_peaks.size());
            mismatches++;
        end
        $display("Covered %0d grid settings, %0d item transactions, %0d peaks compared,",
                 grids_run, accepted_items, peaks_checked);
        $display("with edge, tie, flush and restart cases; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("grid_local_maximum_detector test passed");
        else
            $display("grid_local_maximum_detector test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("grid_local_maximum_detector test failed");
        $finish;
    end

endmodule

FILE: files.f
sv/gld_pkg.sv
sv/gld_ram.sv
sv/grid_local_maximum_detector.sv
tb/testbench.sv
